// ----- rtl/aes_round_linear_layer_top_macros.svh -----
// Assertion macros for the AES round linear layer
`ifndef AES_ROUND_LINEAR_LAYER_TOP_MACROS_SVH
`define AES_ROUND_LINEAR_LAYER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define AES_RLL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("aes_rll: implication check failed");

// Next-cycle implication, disabled in reset
`define AES_RLL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes_rll: next-cycle check failed");

`endif

// ----- rtl/aes_rll_pkg.sv -----
package aes_rll_pkg;

  // Key store geometry: one bank per column lane
  localparam int KEY_WORDS  = 60;
  localparam int LANES      = 4;
  localparam int KEY_ROWS   = (KEY_WORDS + LANES - 1) / LANES;
  localparam int ROW_W      = $clog2(KEY_ROWS);
  localparam int ADD_ROUNDS = KEY_WORDS / LANES;

  // Action codes
  localparam logic [2:0] ACT_LOAD_KEY  = 3'd0;
  localparam logic [2:0] ACT_SHIFT     = 3'd1;
  localparam logic [2:0] ACT_INV_SHIFT = 3'd2;
  localparam logic [2:0] ACT_MIX       = 3'd3;
  localparam logic [2:0] ACT_INV_MIX   = 3'd4;
  localparam logic [2:0] ACT_ADD_KEY   = 3'd5;

  // Four 32-bit columns, column 0 in the low bits
  typedef logic [LANES-1:0][31:0] state_cols_t;

  // Per-lane control for the stage under work
  typedef struct packed {
    logic [2:0] action;
    logic       add_ok;
  } lane_ctl_t;

  // Status of the stage feeding the output register
  typedef struct packed {
    logic valid;
    logic error;
  } stage_stat_t;

endpackage

// ----- rtl/aes_rll_req_if.sv -----
interface aes_rll_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] block_lo;
  logic [63:0] block_hi;
  logic [31:0] key_word;
  logic [5:0]  word_index;
  logic [3:0]  round;

  modport source (
    output valid, action, block_lo, block_hi, key_word, word_index, round,
    input  ready
  );
  modport sink (
    input  valid, action, block_lo, block_hi, key_word, word_index, round,
    output ready
  );
endinterface

// ----- rtl/aes_rll_rsp_if.sv -----
interface aes_rll_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  logic        error;

  modport source (
    output valid, result_lo, result_hi, error,
    input  ready
  );
  modport sink (
    input  valid, result_lo, result_hi, error,
    output ready
  );
endinterface

// ----- rtl/aes_rll_lane.sv -----
module aes_rll_lane (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [aes_rll_pkg::ROW_W-1:0] wr_row,
  input  logic [31:0]                   wr_data,
  input  logic                          rd_en,
  input  logic [aes_rll_pkg::ROW_W-1:0] rd_row,
  input  aes_rll_pkg::lane_ctl_t        ctl,
  input  logic [31:0]                   col,
  input  logic [31:0]                   fwd_col,
  input  logic [31:0]                   inv_col,
  output logic [31:0]                   col_out
);
  import aes_rll_pkg::*;

  logic [31:0] key_bank [KEY_ROWS];
  logic [31:0] key;

  // Multiply by x modulo x^8+x^4+x^3+x+1
  function automatic logic [7:0] xtime(logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // MixColumns or InvMixColumns of one column
  function automatic logic [31:0] mix_col(logic [31:0] c, logic inverse);
    logic [3:0][7:0] a;
    logic [3:0][3:0][7:0] prod;
    logic [3:0][7:0] res;
    logic [7:0] x2, x4, x8;
    a = c;
    for (int j = 0; j < 4; j++) begin
      x2 = xtime(a[j]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      if (inverse) begin
        prod[j][0] = x8 ^ x4 ^ x2;
        prod[j][1] = x8 ^ x2 ^ a[j];
        prod[j][2] = x8 ^ x4 ^ a[j];
        prod[j][3] = x8 ^ a[j];
      end else begin
        prod[j][0] = x2;
        prod[j][1] = x2 ^ a[j];
        prod[j][2] = a[j];
        prod[j][3] = a[j];
      end
    end
    for (int r = 0; r < 4; r++) begin
      res[r] = 8'h00;
      for (int j = 0; j < 4; j++) begin
        res[r] = res[r] ^ prod[j][(j - r + 4) % 4];
      end
    end
    mix_col = res;
  endfunction

  // Write the key bank and register the word read for add key
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_bank[wr_row] <= wr_data;
    end
    if (rd_en) begin
      key <= key_bank[rd_row];
    end
  end

  // Select this lane's column result
  always_comb begin
    case (ctl.action)
      ACT_SHIFT:     col_out = fwd_col;
      ACT_INV_SHIFT: col_out = inv_col;
      ACT_MIX:       col_out = mix_col(col, 1'b0);
      ACT_INV_MIX:   col_out = mix_col(col, 1'b1);
      ACT_ADD_KEY:   col_out = ctl.add_ok ? (col ^ key) : col;
      default:       col_out = col;
    endcase
  end

endmodule

// ----- rtl/aes_rll_merge.sv -----
module aes_rll_merge (
  input  logic                     clk,
  input  logic                     rst,
  input  aes_rll_pkg::stage_stat_t stat,
  input  aes_rll_pkg::state_cols_t cols,
  output logic                     advance,
  aes_rll_rsp_if.source            rsp
);
  import aes_rll_pkg::*;

  // Move the stage into the output register when it is empty or drained
  assign advance = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= stat.valid;
    end
  end

  // Join the lane columns into the result transaction
  always_ff @(posedge clk) begin
    if (advance && stat.valid) begin
      rsp.result_lo <= {cols[1], cols[0]};
      rsp.result_hi <= {cols[3], cols[2]};
      rsp.error     <= stat.error;
    end
  end

endmodule

// ----- rtl/aes_round_linear_layer_top.sv -----
// Channel  Role    Payload
// req      sink    action, block_lo, block_hi, key_word, word_index, round
// rsp      source  result_lo, result_hi, error
//
// One transaction per cycle while rsp is not stalled; each result passes stage one, then the output register.
// Stage one registers the request and reads one key word from each of the four
// column-lane key banks; the lanes compute, and the output register takes the result.
// Reset (rst, synchronous) empties both stages; the key banks are not cleared.
// A stalled rsp holds its result; req stays ready while stage one can move on.
module aes_round_linear_layer_top (
  input  logic         clk,
  input  logic         rst,
  aes_rll_req_if.sink  req,
  aes_rll_rsp_if.source rsp
);
  import aes_rll_pkg::*;

  logic            accept;
  logic            advance;
  logic            load_ok;
  logic            add_ok;
  logic            valid1;
  logic            error1;
  lane_ctl_t       ctl1;
  logic [15:0][7:0] block1;
  state_cols_t     cols1;
  state_cols_t     fwd_cols;
  state_cols_t     inv_cols;
  state_cols_t     lane_out;
  logic [3:0][3:0][7:0] fwd_bytes;
  logic [3:0][3:0][7:0] inv_bytes;
  stage_stat_t     stat;

  // Accept while stage one is empty or moving on
  assign req.ready = !valid1 || advance;
  assign accept    = req.valid && req.ready;

  // Range checks on the key store
  assign load_ok = req.word_index < 6'(KEY_WORDS);
  assign add_ok  = req.round < 4'(ADD_ROUNDS);

  // Stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (advance) begin
      valid1 <= 1'b0;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      block1      <= {req.block_hi, req.block_lo};
      ctl1.action <= req.action;
      ctl1.add_ok <= add_ok;
      error1      <= ((req.action == ACT_LOAD_KEY) && !load_ok) ||
                     ((req.action == ACT_ADD_KEY) && !add_ok);
    end
  end

  // Gather shifted rows for each column
  assign cols1 = block1;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fwd_bytes[c][r] = block1[4 * ((c + r) % 4) + r];
        inv_bytes[c][r] = block1[4 * ((c - r + 4) % 4) + r];
      end
    end
  end
  assign fwd_cols = fwd_bytes;
  assign inv_cols = inv_bytes;

  // Column lanes, each with its own key bank
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic wr_en;
    logic rd_en;
    assign wr_en = accept && (req.action == ACT_LOAD_KEY) && load_ok &&
                   (req.word_index[1:0] == 2'(g));
    assign rd_en = accept && (req.action == ACT_ADD_KEY) && add_ok;

    aes_rll_lane u_lane (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_row  (req.word_index[ROW_W+1:2]),
      .wr_data (req.key_word),
      .rd_en   (rd_en),
      .rd_row  (req.round[ROW_W-1:0]),
      .ctl     (ctl1),
      .col     (cols1[g]),
      .fwd_col (fwd_cols[g]),
      .inv_col (inv_cols[g]),
      .col_out (lane_out[g])
    );
  end

  // Merge lane columns into the output register
  assign stat.valid = valid1;
  assign stat.error = error1;

  aes_rll_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .cols    (lane_out),
    .advance (advance),
    .rsp     (rsp)
  );

endmodule

// ----- rtl/aes_rll_checker.sv -----
`include "aes_round_linear_layer_top_macros.svh"

module aes_rll_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] rsp_lo,
  input logic [63:0] rsp_hi,
  input logic        rsp_error
);

  // Hold a stalled result transaction
  `AES_RLL_ASSERT_NXT(a_rsp_valid_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `AES_RLL_ASSERT_NXT(a_rsp_data_hold, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_lo) && $stable(rsp_hi) && $stable(rsp_error))

  // Stay ready while the output register is empty
  `AES_RLL_ASSERT_IMP(a_ready_when_empty, clk, rst, !rsp_valid, req_ready)

  // Every accepted request is followed by a valid result after stage one and the output register
  `AES_RLL_ASSERT_IMP(a_result_follows, clk, rst, req_valid && req_ready, ##2 rsp_valid)

endmodule

bind aes_round_linear_layer_top aes_rll_checker u_aes_rll_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_lo    (rsp.result_lo),
  .rsp_hi    (rsp.result_hi),
  .rsp_error (rsp.error)
);
